/* rtl/core/qte_pkg.sv */
// ----------------------------------------------------------------------------
// Quaternion to Euler converter package
// Shared payload types, CORDIC angle table and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } qte_in_t;

    typedef struct packed {
        logic signed [14:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic               pitch_clamped;
    } qte_out_t;

    // Products at scale 2^30 = 1.0.
    typedef struct packed {
        logic signed [33:0] sx;
        logic signed [33:0] syc;
        logic signed [33:0] cyc;
        logic signed [33:0] szc;
        logic signed [33:0] czc;
        logic               clamped;
    } qte_ops_t;

    // One CORDIC vectoring channel.
    typedef struct packed {
        logic signed [37:0] x;
        logic signed [37:0] y;
        logic signed [33:0] z;
        logic               zero;
    } qte_vec_t;

    // Channel 2 is pitch, 1 is yaw, 0 is roll.
    typedef struct packed {
        qte_vec_t [2:0] ch;
        logic           clamped;
        logic           sx_neg;
    } qte_cord_t;

    localparam int TABLE_LEN = 24;
    localparam int SQRT_CELLS = 31;

    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
    localparam logic signed [16:0] PI_Q13 = 17'sd25736;

    localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

endpackage

`default_nettype wire

/* rtl/core/qte_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the integer square root; carries the operands along.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_sqrt_cell #(
    parameter int BIT_POS = 60
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             valid_in,
    input  wire logic [60:0]      rem_in,
    input  wire logic [60:0]      root_in,
    input  qte_pkg::qte_ops_t     ops_in,
    output logic                  valid_out,
    output logic [60:0]           rem_out,
    output logic [60:0]           root_out,
    output qte_pkg::qte_ops_t     ops_out
);

    localparam logic [61:0] BIT = 62'd1 << BIT_POS;

    logic              valid_reg;
    logic [60:0]       rem_reg, rem_next;
    logic [60:0]       root_reg, root_next;
    qte_pkg::qte_ops_t ops_reg;
    logic [61:0]       trial;

    always_comb
    begin
        trial = {1'b0, root_in} + BIT;
        if ({1'b0, rem_in} >= trial)
        begin
            rem_next  = rem_in - trial[60:0];
            root_next = (root_in >> 1) + BIT[60:0];
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        ops_reg  <= ops_in;
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign ops_out   = ops_reg;

endmodule

`default_nettype wire

/* rtl/core/qte_cordic_cell.sv */
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring micro-rotation on each of the three angle channels.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid_in,
    input  qte_pkg::qte_cord_t data_in,
    output logic               valid_out,
    output qte_pkg::qte_cord_t data_out
);

    localparam logic signed [33:0] STEP = {2'b00, qte_pkg::ATAN_TAB[STAGE]};

    logic               valid_reg;
    qte_pkg::qte_cord_t data_reg, data_next;
    logic signed [37:0] xs, ys;

    always_comb
    begin
        data_next = data_in;
        xs = '0;
        ys = '0;
        for (int c = 0; c < 3; c++)
        begin
            xs = data_in.ch[c].x >>> STAGE;
            ys = data_in.ch[c].y >>> STAGE;
            if (!data_in.ch[c].y[37])
            begin
                data_next.ch[c].x = data_in.ch[c].x + ys;
                data_next.ch[c].y = data_in.ch[c].y - xs;
                data_next.ch[c].z = data_in.ch[c].z + STEP;
            end
            else
            begin
                data_next.ch[c].x = data_in.ch[c].x - ys;
                data_next.ch[c].y = data_in.ch[c].y + xs;
                data_next.ch[c].z = data_in.ch[c].z - STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

/* rtl/core/quat_to_euler_convert.sv */
// ----------------------------------------------------------------------------
// Quaternion to Euler angle converter
// Q1.15 quaternion in, three Q3.13 angles and a pitch clamp flag out.
// ----------------------------------------------------------------------------
// The block takes one quaternion every clock cycle; busy never rises. Each
// result appears on result for one cycle with done high, 36 + CORDIC_STAGES
// cycles after its start transfer (CORDIC_STAGES counted up to 24), and the
// receiver must take it then. The latency is set by the 31-cell square root
// chain used for the pitch cosine followed by the chain of CORDIC cells.
`default_nettype none

module quat_to_euler_convert #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  qte_pkg::qte_in_t   quat,
    output logic               done,
    output qte_pkg::qte_out_t  result
);

    localparam int NUM_CELLS = (CORDIC_STAGES > qte_pkg::TABLE_LEN) ?
                               qte_pkg::TABLE_LEN : CORDIC_STAGES;
    localparam int NSQ = qte_pkg::SQRT_CELLS;

    // Products.
    logic               v1_reg;
    logic signed [31:0] wx_reg, yz_reg, wy_reg, xz_reg, xx_reg, yy_reg;
    logic signed [31:0] wz_reg, xy_reg, zz_reg;

    // Sums.
    logic               v2_reg;
    qte_pkg::qte_ops_t  ops2_reg, ops2_next;

    // Square of sine of pitch.
    logic               v3_reg;
    qte_pkg::qte_ops_t  ops3_reg;
    logic [60:0]        rem3_reg, rem3_next;
    logic signed [30:0] sx_sq_in;
    logic signed [61:0] sx_sq;

    logic               sq_valid [NSQ+1];
    logic [60:0]        sq_rem   [NSQ+1];
    logic [60:0]        sq_root  [NSQ+1];
    qte_pkg::qte_ops_t  sq_ops   [NSQ+1];

    logic               cd_valid [NUM_CELLS+1];
    qte_pkg::qte_cord_t cd_data  [NUM_CELLS+1];
    qte_pkg::qte_cord_t pre_next;
    logic signed [33:0] pre_y [3];
    logic signed [33:0] pre_x [3];

    logic               done_reg;
    qte_pkg::qte_out_t  result_reg, result_next;
    logic signed [33:0] rnd [3];
    logic signed [16:0] ang [3];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wx_reg <= quat.quat_w * quat.quat_x;
        yz_reg <= quat.quat_y * quat.quat_z;
        wy_reg <= quat.quat_w * quat.quat_y;
        xz_reg <= quat.quat_x * quat.quat_z;
        xx_reg <= quat.quat_x * quat.quat_x;
        yy_reg <= quat.quat_y * quat.quat_y;
        wz_reg <= quat.quat_w * quat.quat_z;
        xy_reg <= quat.quat_x * quat.quat_y;
        zz_reg <= quat.quat_z * quat.quat_z;
    end

    always_comb
    begin
        ops2_next.sx  = (34'(wx_reg) - 34'(yz_reg)) <<< 1;
        ops2_next.syc = (34'(wy_reg) + 34'(xz_reg)) <<< 1;
        ops2_next.cyc = (34'sd1 <<< 30) - ((34'(xx_reg) + 34'(yy_reg)) <<< 1);
        ops2_next.szc = (34'(wz_reg) + 34'(xy_reg)) <<< 1;
        ops2_next.czc = (34'sd1 <<< 30) - ((34'(xx_reg) + 34'(zz_reg)) <<< 1);
        ops2_next.clamped = (ops2_next.sx >= (34'sd1 <<< 30)) ||
                            (ops2_next.sx <= -(34'sd1 <<< 30));
    end

    always_ff @(posedge clk)
    begin
        ops2_reg <= ops2_next;
    end

    // A clamped pitch squares zero; its angle is replaced at the end.
    always_comb
    begin
        sx_sq_in  = ops2_reg.clamped ? 31'sd0 : ops2_reg.sx[30:0];
        sx_sq     = sx_sq_in * sx_sq_in;
        rem3_next = (61'd1 << 60) - sx_sq[60:0];
    end

    always_ff @(posedge clk)
    begin
        ops3_reg <= ops2_reg;
        rem3_reg <= rem3_next;
    end

    assign sq_valid[0] = v3_reg;
    assign sq_rem[0]   = rem3_reg;
    assign sq_root[0]  = '0;
    assign sq_ops[0]   = ops3_reg;

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        qte_sqrt_cell #(
            .BIT_POS (60 - 2 * k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (sq_valid[k]),
            .rem_in    (sq_rem[k]),
            .root_in   (sq_root[k]),
            .ops_in    (sq_ops[k]),
            .valid_out (sq_valid[k+1]),
            .rem_out   (sq_rem[k+1]),
            .root_out  (sq_root[k+1]),
            .ops_out   (sq_ops[k+1])
        );
    end

    // Fold the left half plane into the right before the micro-rotations.
    always_comb
    begin
        pre_y[2] = sq_ops[NSQ].sx;
        pre_x[2] = {3'b000, sq_root[NSQ][30:0]};
        pre_y[1] = sq_ops[NSQ].syc;
        pre_x[1] = sq_ops[NSQ].cyc;
        pre_y[0] = sq_ops[NSQ].szc;
        pre_x[0] = sq_ops[NSQ].czc;
        pre_next.clamped = sq_ops[NSQ].clamped;
        pre_next.sx_neg  = sq_ops[NSQ].sx[33];
        for (int c = 0; c < 3; c++)
        begin
            pre_next.ch[c].zero = (pre_x[c] == '0) && (pre_y[c] == '0);
            if (!pre_x[c][33])
            begin
                pre_next.ch[c].x = 38'(pre_x[c]);
                pre_next.ch[c].y = 38'(pre_y[c]);
                pre_next.ch[c].z = '0;
            end
            else if (!pre_y[c][33])
            begin
                pre_next.ch[c].x = 38'(pre_y[c]);
                pre_next.ch[c].y = -38'(pre_x[c]);
                pre_next.ch[c].z = qte_pkg::HALF_PI_Q30;
            end
            else
            begin
                pre_next.ch[c].x = -38'(pre_y[c]);
                pre_next.ch[c].y = 38'(pre_x[c]);
                pre_next.ch[c].z = -qte_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_valid[0] <= 1'b0;
        end
        else
        begin
            cd_valid[0] <= sq_valid[NSQ];
        end
    end

    always_ff @(posedge clk)
    begin
        cd_data[0] <= pre_next;
    end

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cordic
        qte_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (cd_valid[i]),
            .data_in   (cd_data[i]),
            .valid_out (cd_valid[i+1]),
            .data_out  (cd_data[i+1])
        );
    end

    // Round Q4.30 to Q3.13 half up, then limit the range.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rnd[c] = (cd_data[NUM_CELLS].ch[c].z + 34'sd65536) >>> 17;
            if (cd_data[NUM_CELLS].ch[c].zero)
            begin
                ang[c] = '0;
            end
            else
            begin
                ang[c] = rnd[c][16:0];
            end
        end
        if (ang[1] > qte_pkg::PI_Q13)
        begin
            ang[1] = qte_pkg::PI_Q13;
        end
        else if (ang[1] < -qte_pkg::PI_Q13)
        begin
            ang[1] = -qte_pkg::PI_Q13;
        end
        if (ang[0] > qte_pkg::PI_Q13)
        begin
            ang[0] = qte_pkg::PI_Q13;
        end
        else if (ang[0] < -qte_pkg::PI_Q13)
        begin
            ang[0] = -qte_pkg::PI_Q13;
        end
        if (cd_data[NUM_CELLS].clamped)
        begin
            ang[2] = cd_data[NUM_CELLS].sx_neg ? -qte_pkg::HALF_PI_Q13
                                               : qte_pkg::HALF_PI_Q13;
        end
        else if (ang[2] > qte_pkg::HALF_PI_Q13)
        begin
            ang[2] = qte_pkg::HALF_PI_Q13;
        end
        else if (ang[2] < -qte_pkg::HALF_PI_Q13)
        begin
            ang[2] = -qte_pkg::HALF_PI_Q13;
        end
        result_next.angle_x       = ang[2][14:0];
        result_next.angle_y       = ang[1][15:0];
        result_next.angle_z       = ang[0][15:0];
        result_next.pitch_clamped = cd_data[NUM_CELLS].clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cd_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
